/* src/unsigned_restoring_divider_defines.svh */
// assertion macros shared by the divider checker
`ifndef UNSIGNED_RESTORING_DIVIDER_DEFINES_SVH
`define UNSIGNED_RESTORING_DIVIDER_DEFINES_SVH

// same-cycle implication, sampled on clk, off while in reset
`define URD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("urd check failed");

// next-cycle implication, sampled on clk, off while in reset
`define URD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("urd check failed");

`endif

/* src/urd_pkg.sv */
// shared types and constants of the unsigned restoring divider
package urd_pkg;

  // width of the data fields on the ports
  localparam int PORT_W = 64;

  // one finished result item
  typedef struct packed {
    logic [PORT_W-1:0] quotient;
    logic [PORT_W-1:0] remainder;
    logic              divide_by_zero;
  } urd_res_t;

endpackage

/* src/urd_stage.sv */
// one shift-subtract step of the divider pipeline, registered
module urd_stage import urd_pkg::*; #(
  parameter int W = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         adv,
  input  logic         vld_i,
  input  logic [W-1:0] rem_i,
  input  logic [W-1:0] acc_i,
  input  logic [W-1:0] dvs_i,
  input  logic         dbz_i,
  output logic         vld_o,
  output logic [W-1:0] rem_o,
  output logic [W-1:0] acc_o,
  output logic [W-1:0] dvs_o,
  output logic         dbz_o
);

  logic         vld_r;
  logic [W-1:0] rem_r, rem_nxt;
  logic [W-1:0] acc_r, acc_nxt;
  logic [W-1:0] dvs_r;
  logic         dbz_r;

  logic [W:0]   shifted;
  logic [W+1:0] diff;
  logic         fits;

  // bring in the next dividend bit, trial subtract, keep on no borrow
  always_comb begin
    shifted = {rem_i, acc_i[W-1]};
    diff    = {1'b0, shifted} - {2'b00, dvs_i};
    fits    = ~diff[W+1];
    rem_nxt = fits ? diff[W-1:0] : shifted[W-1:0];
    acc_nxt = {acc_i[W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r <= rem_nxt;
      acc_r <= acc_nxt;
      dvs_r <= dvs_i;
      dbz_r <= dbz_i;
    end
  end

  assign vld_o = vld_r;
  assign rem_o = rem_r;
  assign acc_o = acc_r;
  assign dvs_o = dvs_r;
  assign dbz_o = dbz_r;

endmodule

/* src/urd_out_buf.sv */
// output register with a skid entry behind it
module urd_out_buf import urd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  urd_res_t push_data,
  output logic     room,
  output logic     out_valid,
  input  logic     out_stall,
  output urd_res_t out_data
);

  logic     out_vld_r, out_vld_nxt;
  urd_res_t out_dat_r, out_dat_nxt;
  logic     sk_vld_r, sk_vld_nxt;
  urd_res_t sk_dat_r, sk_dat_nxt;
  logic     pop;

  always_comb begin
    pop         = out_vld_r & ~out_stall;
    out_vld_nxt = out_vld_r;
    out_dat_nxt = out_dat_r;
    sk_vld_nxt  = sk_vld_r;
    sk_dat_nxt  = sk_dat_r;
    priority if (sk_vld_r) begin
      if (pop || !out_vld_r) begin
        out_vld_nxt = 1'b1;
        out_dat_nxt = sk_dat_r;
        sk_vld_nxt  = 1'b0;
      end
    end else if (push) begin
      if (pop || !out_vld_r) begin
        out_vld_nxt = 1'b1;
        out_dat_nxt = push_data;
      end else begin
        sk_vld_nxt = 1'b1;
        sk_dat_nxt = push_data;
      end
    end else if (pop) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      sk_vld_r  <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
      sk_vld_r  <= sk_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_dat_r <= out_dat_nxt;
    sk_dat_r  <= sk_dat_nxt;
  end

  assign room      = ~sk_vld_r;
  assign out_valid = out_vld_r;
  assign out_data  = out_dat_r;

endmodule

/* src/unsigned_restoring_divider.sv */
// top level of the pipelined unsigned restoring divider
// Unsigned restoring divider, one division per clock while in_stall is low.
// Each item carries a dividend and a divisor; only their low DATA_WIDTH bits
// are used. The item runs through DATA_WIDTH register stages, each doing one
// shift-subtract step (one quotient bit, most significant first), then lands
// in an output register. Throughput is one item per cycle while in_stall is
// low; the result passes through the stage chain (the first stage captures
// the item at the accepting edge) and then the output register before it
// shows on out_valid. A zero divisor gives quotient and remainder of zero
// with out_divide_by_zero set. Results come out in input order. A skid entry
// behind the output register lets the pipe move one more item while a result
// is held by out_stall; in_stall rises once the skid entry is full and drops
// when it drains.
module unsigned_restoring_divider import urd_pkg::*; #(
  parameter int DATA_WIDTH = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [PORT_W-1:0] in_dividend,
  input  logic [PORT_W-1:0] in_divisor,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [PORT_W-1:0] out_quotient,
  output logic [PORT_W-1:0] out_remainder,
  output logic              out_divide_by_zero
);

  localparam int W = DATA_WIDTH;

  // stage taps: index 0 is the pipe input, index k the output of stage k
  logic         vld_s [W+1];
  logic [W-1:0] rem_s [W+1];
  logic [W-1:0] acc_s [W+1];
  logic [W-1:0] dvs_s [W+1];
  logic         dbz_s [W+1];

  logic     adv;
  logic     room;
  urd_res_t res;
  urd_res_t out_data;

  // whole pipe moves together whenever the skid entry is free
  assign adv      = room;
  assign in_stall = ~room;

  // partial remainder starts at zero, dividend waits in the shift register
  assign vld_s[0] = in_valid;
  assign rem_s[0] = '0;
  assign acc_s[0] = in_dividend[W-1:0];
  assign dvs_s[0] = in_divisor[W-1:0];
  assign dbz_s[0] = (in_divisor[W-1:0] == '0);

  for (genvar k = 0; k < W; k++) begin : g_step
    urd_stage #(.W(W)) u_stage (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (adv),
      .vld_i (vld_s[k]),
      .rem_i (rem_s[k]),
      .acc_i (acc_s[k]),
      .dvs_i (dvs_s[k]),
      .dbz_i (dbz_s[k]),
      .vld_o (vld_s[k+1]),
      .rem_o (rem_s[k+1]),
      .acc_o (acc_s[k+1]),
      .dvs_o (dvs_s[k+1]),
      .dbz_o (dbz_s[k+1])
    );
  end

  // after the last step the shift register holds the quotient;
  // a zero divisor would leave all ones there, so force zeros
  always_comb begin
    res.divide_by_zero = dbz_s[W];
    res.quotient       = dbz_s[W] ? '0 : PORT_W'(acc_s[W]);
    res.remainder      = dbz_s[W] ? '0 : PORT_W'(rem_s[W]);
  end

  urd_out_buf u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (adv & vld_s[W]),
    .push_data (res),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign out_quotient       = out_data.quotient;
  assign out_remainder      = out_data.remainder;
  assign out_divide_by_zero = out_data.divide_by_zero;

endmodule

/* src/urd_checker.sv */
// port-level checks for the unsigned restoring divider, with bind
`include "unsigned_restoring_divider_defines.svh"

module urd_checker import urd_pkg::*; #(
  parameter int DATA_WIDTH = 64
) (
  input logic              clk,
  input logic              rst_n,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [PORT_W-1:0] out_quotient,
  input logic [PORT_W-1:0] out_remainder,
  input logic              out_divide_by_zero
);

  // whole result payload as one word
  logic [2*PORT_W:0] out_word;

  assign out_word = {out_quotient, out_remainder, out_divide_by_zero};

  // a held result stays put
  `URD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_word))

  // zero divisor gives zero results
  `URD_ASSERT_NOW(a_dbz_zero, out_valid && out_divide_by_zero, out_quotient == '0 && out_remainder == '0)

  // results never reach above the data width
  `URD_ASSERT_NOW(a_out_narrow, out_valid, ((out_quotient | out_remainder) >> DATA_WIDTH) == '0)

  // input backs up only after a result was held at the output
  `URD_ASSERT_NOW(a_stall_cause, in_stall, $past(out_valid && out_stall))

endmodule

bind unsigned_restoring_divider urd_checker #(.DATA_WIDTH(DATA_WIDTH)) u_urd_checker (.*);

/* verif/unsigned_restoring_divider_tb.sv */
// self-checking testbench for the unsigned restoring divider
module unsigned_restoring_divider_tb import urd_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // data width the divider is built with; the prediction masks to it
  localparam int DW = 64;
  // directed items come first, then this many random ones
  localparam int N_RANDOM = 1500;
  // items at the end of the run that go through with no idling on either side
  localparam int N_QUIET_TAIL = 150;
  // stage count of the divider pipe, sizes the wait at the end of the run
  localparam int PIPE_LAT = DW;
  // hard ceiling on the run, far above the slowest legal run
  localparam int CYCLE_LIMIT = 400000;

  // one division request plus the flow hints the driver follows
  typedef struct {
    logic [PORT_W-1:0] dividend;
    logic [PORT_W-1:0] divisor;
    bit                drain_first; // hold back until every quotient is back
    bit                gappy;       // sender may idle after this item
    bit                quiet_tail;  // from here on nobody idles
  } div_req_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [PORT_W-1:0] in_dividend = '0;
  logic [PORT_W-1:0] in_divisor = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [PORT_W-1:0] out_quotient;
  logic [PORT_W-1:0] out_remainder;
  logic              out_divide_by_zero;

  div_req_t pending_divisions[$];
  urd_res_t quot_rem_due[$];

  // input item taken at the last rising edge
  logic in_taken = 1'b0;
  // set once the quiet tail starts; stops all idling
  logic calm_phase = 1'b0;
  // receiver switches between stalling stretches and clean stretches
  bit   rx_busy = 1'b1;
  int   tx_gap = 0;
  int   rx_gap = 0;

  int   n_cycles = 0;
  int   n_errors = 0;
  int   n_accepted = 0;
  int   n_checked = 0;
  int   n_zero_div = 0;
  int   n_wide_div = 0;

  unsigned_restoring_divider #(
    .DATA_WIDTH(DW)
  ) u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_dividend        (in_dividend),
    .in_divisor         (in_divisor),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_quotient       (out_quotient),
    .out_remainder      (out_remainder),
    .out_divide_by_zero (out_divide_by_zero)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 0;
  end

  // expected quotient and remainder of one division, zero divisor flagged
  function automatic urd_res_t divide_and_mod(input logic [PORT_W-1:0] num,
                                              input logic [PORT_W-1:0] den);
    logic [PORT_W-1:0] msk;
    logic [PORT_W-1:0] a;
    logic [PORT_W-1:0] b;
    urd_res_t          res;
    // only the low DW bits of either operand take part
    msk = {PORT_W{1'b1}} >> (PORT_W - DW);
    a   = num & msk;
    b   = den & msk;
    if (b == '0) begin
      res.quotient       = '0;
      res.remainder      = '0;
      res.divide_by_zero = 1'b1;
    end else begin
      res.quotient       = a / b;
      res.remainder      = a % b;
      res.divide_by_zero = 1'b0;
    end
    return res;
  endfunction

  function automatic logic [PORT_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // one line per bad field, and a running count
  task automatic report_mismatch(input string what, input logic [PORT_W-1:0] got,
                                 input logic [PORT_W-1:0] want);
    $display("ERROR: %s got %h want %h at result %0d", what, got, want, n_checked);
    n_errors++;
  endtask

  task automatic add_division(input logic [PORT_W-1:0] a, input logic [PORT_W-1:0] b,
                              input bit drain, input bit gaps, input bit tail);
    div_req_t req;
    req.dividend    = a;
    req.divisor     = b;
    req.drain_first = drain;
    req.gappy       = gaps;
    req.quiet_tail  = tail;
    pending_divisions.push_back(req);
  endtask

  // driver: presents the next item at the falling edge, holds it while stalled
  always @(negedge clk) begin
    div_req_t nxt;
    if (rst_n && !(in_valid && !in_taken)) begin
      if (tx_gap > 0) begin
        // idle burst in progress
        tx_gap--;
        in_valid <= 1'b0;
      end else if (pending_divisions.size() == 0 ||
                   (pending_divisions[0].drain_first && quot_rem_due.size() != 0)) begin
        // nothing left, or waiting for the pipe to empty out
        in_valid <= 1'b0;
      end else begin
        nxt = pending_divisions.pop_front();
        in_valid    <= 1'b1;
        in_dividend <= nxt.dividend;
        in_divisor  <= nxt.divisor;
        if (nxt.quiet_tail) begin
          calm_phase <= 1'b1;
        end
        // after this item is taken, maybe idle before the next one
        if (nxt.gappy && !nxt.quiet_tail && $urandom_range(0, 3) == 0) begin
          tx_gap = $urandom_range(1, 7);
        end
      end
    end
  end

  // receiver: random stall bursts, none in the quiet tail
  always @(negedge clk) begin
    if ($urandom_range(0, 149) == 0) begin
      rx_busy = !rx_busy;
    end
    if (!rst_n || calm_phase) begin
      out_stall <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      out_stall <= 1'b1;
    end else if (rx_busy && $urandom_range(0, 5) == 0) begin
      rx_gap = $urandom_range(0, 6);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // monitor: record accepted items, check finished results, watch the clock
  always @(posedge clk) begin
    urd_res_t want;
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("ERROR: run exceeded %0d cycles", CYCLE_LIMIT);
      $display("unsigned_restoring_divider: mismatch");
      $finish;
    end else begin
      in_taken <= in_valid && !in_stall;
      if (rst_n) begin
        if (in_valid && !in_stall) begin
          quot_rem_due.push_back(divide_and_mod(in_dividend, in_divisor));
          n_accepted++;
          if (in_divisor[DW-1]) begin
            n_wide_div++;
          end
        end
        if (out_valid && !out_stall) begin
          if (quot_rem_due.size() == 0) begin
            report_mismatch("result with no division pending, quotient", out_quotient, '0);
          end else begin
            want = quot_rem_due.pop_front();
            if (out_quotient !== want.quotient) begin
              report_mismatch("quotient", out_quotient, want.quotient);
            end
            if (out_remainder !== want.remainder) begin
              report_mismatch("remainder", out_remainder, want.remainder);
            end
            if (out_divide_by_zero !== want.divide_by_zero) begin
              report_mismatch("divide_by_zero", PORT_W'(out_divide_by_zero),
                              PORT_W'(want.divide_by_zero));
            end
            if (want.divide_by_zero) begin
              n_zero_div++;
            end
          end
          n_checked++;
        end
      end
    end
  end

  // stimulus and end of run
  initial begin
    logic [PORT_W-1:0] ones;
    logic [PORT_W-1:0] half;
    logic [PORT_W-1:0] a;
    logic [PORT_W-1:0] b;
    bit                seg_gappy;
    bit                tail;
    int                mode;

    ones        = {PORT_W{1'b1}};
    half        = {1'b1, {(PORT_W-1){1'b0}}};
    rst_n       = 1'b0;

    // directed: zero divisor in several forms
    add_division('0, '0, 0, 0, 0);
    add_division(64'd123, '0, 0, 1, 0);
    add_division(ones, '0, 0, 0, 0);
    // extremes of both operands
    add_division('0, 64'd1, 0, 0, 0);
    add_division(ones, 64'd1, 0, 1, 0);
    add_division(ones, ones, 0, 0, 0);
    add_division(64'd1, ones, 0, 0, 0);
    add_division(ones - 1, ones, 0, 0, 0);
    add_division(64'd1, 64'd1, 0, 0, 0);
    add_division(ones, 64'd2, 0, 0, 0);
    add_division(ones, 64'd3, 0, 0, 0);
    // divisor at and around half the range: the carried-out bit matters here
    add_division(ones, half, 0, 0, 0);
    add_division(ones, half + 1, 0, 1, 0);
    add_division(half, half, 0, 0, 0);
    add_division(half - 1, half, 0, 0, 0);
    add_division(ones, half - 1, 0, 0, 0);
    add_division(half, 64'd1, 0, 0, 0);
    // small values and dividend below divisor
    add_division(64'd100, 64'd7, 0, 0, 0);
    add_division(64'd7, 64'd100, 0, 0, 0);
    // alternating bit patterns
    add_division({32{2'b01}}, {32{2'b10}}, 0, 0, 0);
    add_division({32{2'b10}}, {32{2'b01}}, 0, 0, 0);

    // random part, sender idling switched on and off per segment of 64
    seg_gappy = 1'b1;
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % 64 == 0) begin
        seg_gappy = ($urandom_range(0, 2) != 0);
      end
      tail = (i >= N_RANDOM - N_QUIET_TAIL);
      mode = $urandom_range(0, 9);
      a = rand_word();
      b = rand_word();
      case (mode)
        0: begin
          // zero divisor with any dividend
          b = '0;
        end
        1: begin
          // full-width operands as drawn
        end
        2: begin
          // narrow divisor, wide quotient
          b = b >> $urandom_range(1, PORT_W - 1);
        end
        3: begin
          // dividend built as q*b + r with r below b
          b = b >> $urandom_range(PORT_W / 2, PORT_W - 1);
          if (b == '0) begin
            b = 64'd1;
          end
          a = (a >> $urandom_range(PORT_W / 2, PORT_W - 1)) * b
              + (rand_word() % b);
        end
        4: begin
          // divisor in the upper half of the range
          b[PORT_W-1] = 1'b1;
        end
        5: begin
          // dividend below divisor, quotient zero
          if (a > b) begin
            a = a ^ b;
            b = a ^ b;
            a = a ^ b;
          end
          if (a == b) begin
            a = a - 1;
          end
        end
        6: begin
          // equal operands
          a = b;
        end
        default: begin
          // both operands of random magnitude
          a = a >> $urandom_range(0, PORT_W - 1);
          b = b >> $urandom_range(0, PORT_W - 1);
        end
      endcase
      // the sender drains the pipe twice: once after the directed items, once mid-run
      add_division(a, b, (i == 0 || i == N_RANDOM / 2), seg_gappy, tail);
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_divisions.size() != 0 || in_valid || quot_rem_due.size() != 0) begin
      @(posedge clk);
    end
    // let anything stray fall out of the pipe before the verdict
    repeat (2 * PIPE_LAT + 10) @(posedge clk);

    $display("run covered %0d divisions checked of %0d accepted in %0d cycles",
             n_checked, n_accepted, n_cycles);
    $display("%0d by a zero divisor, %0d with the divisor top bit set, %0d errors",
             n_zero_div, n_wide_div, n_errors);
    if (n_errors == 0 && quot_rem_due.size() == 0) begin
      $display("unsigned_restoring_divider: match");
    end else begin
      $display("unsigned_restoring_divider: mismatch");
    end
    $finish;
  end

endmodule
